// ===== sv/mlbc_pkg.sv =====
// ============================================================================
// mlbc_pkg: shared types, constants and kernel arithmetic
// Sizes of the multichannel 3x3 line-buffer convolution, the four fixed
// kernels and the per-channel kernel sum used by the datapath.
// ============================================================================
package mlbc_pkg;

   localparam int WINDOW       = 3;
   localparam int FILTERS      = 4;
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_CHANNELS = 8;
   localparam int PIXEL_BITS   = 8;

   localparam int CH_BITS   = $clog2(MAX_CHANNELS);
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = 12;
   localparam int FILT_BITS = $clog2(FILTERS);

   // Configuration register widths.
   localparam int CC_BITS        = 4;
   localparam int IW_BITS        = 11;
   localparam int IH_BITS        = 12;
   localparam int CSR_DATA_BITS  = 12;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CC_BITS-1:0] CC_RESET = CC_BITS'(1);
   localparam logic [IW_BITS-1:0] IW_RESET = IW_BITS'(1024);
   localparam logic [IH_BITS-1:0] IH_RESET = IH_BITS'(1024);

   // One kernel over one channel adds at most eight pixels.
   localparam int KSUM_BITS = 11;
   localparam int SUM_BITS  = 15;

   localparam int ROW_ADDR_BITS = CH_BITS + COL_BITS;
   localparam int ROW_DEPTH     = MAX_CHANNELS * MAX_WIDTH;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_IMAGE_WIDTH   = 2'd1,
      CSR_IMAGE_HEIGHT  = 2'd2
   } csr_reg_type;

   typedef logic [PIXEL_BITS-1:0]    pix_type;
   typedef logic [KSUM_BITS-1:0]     ksum_type;
   typedef logic [SUM_BITS-1:0]      sum_type;
   typedef logic [ROW_ADDR_BITS-1:0] row_addr_type;

   // One window column, index 0 is the top row.
   typedef pix_type [WINDOW-1:0] col_type;
   // Full window, index 0 is the oldest column.
   typedef col_type [WINDOW-1:0] window_type;

   typedef ksum_type [FILTERS-1:0] ksum_vec_type;
   typedef sum_type  [FILTERS-1:0] sum_vec_type;

   // Line buffer entry of one channel and column: the two previous rows.
   typedef struct packed {
      pix_type older;
      pix_type newer;
   } row_word_type;

   // Window history of one channel: the two previous columns.
   typedef struct packed {
      col_type older;
      col_type newer;
   } win_word_type;

   // Four finished sums of one pixel, handed to the result serializer.
   typedef struct packed {
      sum_vec_type sums;
   } sum_group_type;

   // Kernels, indexed [filter][row][column].
   localparam bit KERNEL [FILTERS][WINDOW][WINDOW] = '{
      '{'{1'b1, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b1}},
      '{'{1'b0, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0}},
      '{'{1'b1, 1'b1, 1'b1}, '{1'b1, 1'b0, 1'b1}, '{1'b1, 1'b1, 1'b1}},
      '{'{1'b0, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b0}}
   };

   // Sum of the window pixels selected by one kernel.
   function automatic ksum_type kernel_sum(input window_type win,
                                           input logic [FILT_BITS-1:0] f);
      ksum_type s;
      s = '0;
      for (int r = 0; r < WINDOW; r++) begin
         for (int c = 0; c < WINDOW; c++) begin
            if (KERNEL[f][r][c]) begin
               s = s + KSUM_BITS'(win[c][r]);
            end
         end
      end
      return s;
   endfunction

endpackage

// ===== sv/mlbc_rsp_serializer.sv =====
// ============================================================================
// mlbc_rsp_serializer: four-beat result output
// Takes the four sums of a pixel as one group and sends them as four beats,
// with a second group slot that takes the next group while one is sent.
// ============================================================================
module mlbc_rsp_serializer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load_valid,
   output logic                                 load_ready,
   input  mlbc_pkg::sum_group_type              load_group,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mlbc_pkg::SUM_BITS-1:0]        rsp_sum,
   output logic [mlbc_pkg::FILT_BITS-1:0]       rsp_filter_index,
   output logic                                 rsp_last
);

   logic                              cur_valid_ff, cur_valid_in;
   logic [mlbc_pkg::FILT_BITS-1:0]    beat_ff, beat_in;
   mlbc_pkg::sum_group_type           cur_ff, cur_in;
   logic                              pend_valid_ff, pend_valid_in;
   mlbc_pkg::sum_group_type           pend_ff, pend_in;

   logic fire;
   logic cur_done;
   logic cur_free;
   logic load;

   assign load_ready       = !pend_valid_ff;
   assign rsp_valid        = cur_valid_ff;
   assign rsp_sum          = cur_ff.sums[beat_ff];
   assign rsp_filter_index = beat_ff;
   assign rsp_last         = (beat_ff == mlbc_pkg::FILT_BITS'(mlbc_pkg::FILTERS - 1));

   assign fire     = cur_valid_ff && rsp_ready;
   assign cur_done = fire && rsp_last;
   assign cur_free = !cur_valid_ff || cur_done;
   assign load     = load_valid && load_ready;

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      beat_in       = beat_ff;
      cur_in        = cur_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (cur_free) begin
         beat_in = '0;
         if (pend_valid_ff) begin
            cur_in        = pend_ff;
            cur_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (load) begin
            cur_in       = load_group;
            cur_valid_in = 1'b1;
         end else begin
            cur_valid_in = 1'b0;
         end
      end else begin
         if (fire) begin
            beat_in = beat_ff + mlbc_pkg::FILT_BITS'(1);
         end
         if (load) begin
            pend_in       = load_group;
            pend_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         beat_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         beat_ff       <= beat_in;
         pend_valid_ff <= pend_valid_in;
      end
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
   end

`ifndef ASSERT_OFF
   // The waiting slot is only filled while a group is being sent.
   a_pend_needs_cur: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> cur_valid_ff)
      else $error("waiting group without a group in flight");

   // A group is never broken off: a non-final beat is followed by the next one.
   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && rsp_filter_index ==
            $past(rsp_filter_index) + mlbc_pkg::FILT_BITS'(1)))
      else $error("result group interrupted");
`endif

endmodule

// ===== sv/multichannel_line_buffer_conv3x3_unit.sv =====
// ============================================================================
// multichannel_line_buffer_conv3x3_unit: 3x3 line-buffer convolution
// Takes a channel-interleaved raster, one channel value per req beat, and
// for every pixel with row and column of at least two sends four rsp beats:
// the window sums over all channels of the four fixed kernels, filter 0 to 3,
// with rsp_last on the fourth. Other pixels send nothing.
// Throughput: one req beat per cycle while req_ready is high. Each pixel's
// results occupy the rsp port for four beats, so with fewer than four
// channels the pixel rate is set by the single result port.
// Path: a pixel's last channel passes stage 1, stage 2 and the serializer's
// current group register before its first rsp beat is offered.
// rsp stalls are absorbed by two group slots; the pipeline drops req_ready
// only once both are full and the stages behind them are full as well.
// Reset clears counters, valid flags and accumulators and loads the csr
// defaults (one channel, 1024 x 1024); the line buffer is not cleared and
// needs no clearing pass. csr writes are taken on any cycle with the
// write enable high; index 3 is ignored.
// ============================================================================
module multichannel_line_buffer_conv3x3_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [mlbc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mlbc_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mlbc_pkg::PIXEL_BITS-1:0]       req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mlbc_pkg::SUM_BITS-1:0]         rsp_sum,
   output logic [mlbc_pkg::FILT_BITS-1:0]        rsp_filter_index,
   output logic                                  rsp_last
);

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [mlbc_pkg::CC_BITS-1:0] chan_count_ff, chan_count_in;
   logic [mlbc_pkg::IW_BITS-1:0] img_width_ff,  img_width_in;
   logic [mlbc_pkg::IH_BITS-1:0] img_height_ff, img_height_in;

   always_comb begin
      chan_count_in = chan_count_ff;
      img_width_in  = img_width_ff;
      img_height_in = img_height_ff;
      if (csr_write_enable) begin
         unique case (mlbc_pkg::csr_reg_type'(csr_index))
            mlbc_pkg::CSR_CHANNEL_COUNT: begin
               chan_count_in = csr_wdata[mlbc_pkg::CC_BITS-1:0];
            end
            mlbc_pkg::CSR_IMAGE_WIDTH: begin
               img_width_in = csr_wdata[mlbc_pkg::IW_BITS-1:0];
            end
            mlbc_pkg::CSR_IMAGE_HEIGHT: begin
               img_height_in = csr_wdata[mlbc_pkg::IH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective limits: zero counts as one, width and channels saturate.
   logic [mlbc_pkg::CC_BITS-1:0] eff_channels;
   logic [mlbc_pkg::IW_BITS-1:0] eff_width;
   logic [mlbc_pkg::IH_BITS-1:0] eff_height;

   always_comb begin
      if (chan_count_ff == '0) begin
         eff_channels = mlbc_pkg::CC_BITS'(1);
      end else if (chan_count_ff > mlbc_pkg::CC_BITS'(mlbc_pkg::MAX_CHANNELS)) begin
         eff_channels = mlbc_pkg::CC_BITS'(mlbc_pkg::MAX_CHANNELS);
      end else begin
         eff_channels = chan_count_ff;
      end
      if (img_width_ff == '0) begin
         eff_width = mlbc_pkg::IW_BITS'(1);
      end else if (img_width_ff > mlbc_pkg::IW_BITS'(mlbc_pkg::MAX_WIDTH)) begin
         eff_width = mlbc_pkg::IW_BITS'(mlbc_pkg::MAX_WIDTH);
      end else begin
         eff_width = img_width_ff;
      end
      eff_height = (img_height_ff == '0) ? mlbc_pkg::IH_BITS'(1) : img_height_ff;
   end

   // ---------------------------------------------------------------------
   // Stage 0: raster position counters and memory read issue.
   // ---------------------------------------------------------------------
   logic [mlbc_pkg::CH_BITS-1:0]  ch_ff,  ch_in;
   logic [mlbc_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [mlbc_pkg::ROW_BITS-1:0] row_ff, row_in;

   logic accept;
   logic last_ch;
   logic last_col;
   logic last_row;
   logic emit;
   mlbc_pkg::row_addr_type rd_addr;

   assign accept = req_valid && req_ready;

   assign last_ch  = (mlbc_pkg::CC_BITS'(ch_ff) + mlbc_pkg::CC_BITS'(1)) >= eff_channels;
   assign last_col = (mlbc_pkg::IW_BITS'(col_ff) + mlbc_pkg::IW_BITS'(1)) >= eff_width;
   assign last_row = ((mlbc_pkg::ROW_BITS + 1)'(row_ff) + (mlbc_pkg::ROW_BITS + 1)'(1))
                     >= (mlbc_pkg::ROW_BITS + 1)'(eff_height);

   // Sums leave the block only once the window lies fully inside the frame.
   assign emit = (row_ff >= mlbc_pkg::ROW_BITS'(mlbc_pkg::WINDOW - 1)) &&
                 (col_ff >= mlbc_pkg::COL_BITS'(mlbc_pkg::WINDOW - 1));

   assign rd_addr = {ch_ff, col_ff};

   always_comb begin
      ch_in  = ch_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!last_ch) begin
            ch_in = ch_ff + mlbc_pkg::CH_BITS'(1);
         end else begin
            ch_in = '0;
            if (!last_col) begin
               col_in = col_ff + mlbc_pkg::COL_BITS'(1);
            end else begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + mlbc_pkg::ROW_BITS'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Memories. The line buffer holds the two previous rows of every channel
   // and column; the window memory holds the two previous window columns of
   // every channel. Both are read when a beat is accepted and written back
   // when that beat leaves stage 1.
   // ---------------------------------------------------------------------
   mlbc_pkg::row_word_type row_mem [mlbc_pkg::ROW_DEPTH];
   mlbc_pkg::win_word_type win_mem [mlbc_pkg::MAX_CHANNELS];
   mlbc_pkg::row_word_type row_rdata_ff;
   mlbc_pkg::win_word_type win_rdata_ff;

   logic                   wr_en;
   mlbc_pkg::row_addr_type wr_addr;
   mlbc_pkg::row_word_type row_wdata;
   mlbc_pkg::win_word_type win_wdata;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= row_wdata;
      end
      if (accept) begin
         row_rdata_ff <= row_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[wr_addr[mlbc_pkg::ROW_ADDR_BITS-1 -: mlbc_pkg::CH_BITS]] <= win_wdata;
      end
      if (accept) begin
         win_rdata_ff <= win_mem[ch_ff];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: merge the read data with a write-back landing on the same
   // edge as the read, form the window, write back, compute kernel sums.
   // ---------------------------------------------------------------------
   logic                         s1_valid_ff, s1_valid_in;
   mlbc_pkg::pix_type            s1_pixel_ff, s1_pixel_in;
   logic [mlbc_pkg::CH_BITS-1:0] s1_ch_ff, s1_ch_in;
   logic [mlbc_pkg::COL_BITS-1:0] s1_col_ff, s1_col_in;
   logic                         s1_last_ff, s1_last_in;
   logic                         s1_emit_ff, s1_emit_in;
   logic                         s1_row_fwd_ff, s1_row_fwd_in;
   mlbc_pkg::row_word_type       s1_row_fdata_ff, s1_row_fdata_in;
   logic                         s1_win_fwd_ff, s1_win_fwd_in;
   mlbc_pkg::win_word_type       s1_win_fdata_ff, s1_win_fdata_in;

   logic                   s1_go;
   mlbc_pkg::row_word_type row_word;
   mlbc_pkg::win_word_type win_word;
   mlbc_pkg::col_type      new_col;
   mlbc_pkg::window_type   window;
   mlbc_pkg::ksum_vec_type ksum;

   assign req_ready = !s1_valid_ff || s1_go;
   assign wr_en     = s1_valid_ff && s1_go;
   assign wr_addr   = {s1_ch_ff, s1_col_ff};

   assign row_word = s1_row_fwd_ff ? s1_row_fdata_ff : row_rdata_ff;
   assign win_word = s1_win_fwd_ff ? s1_win_fdata_ff : win_rdata_ff;

   always_comb begin
      // New column, top to bottom: older line, newer line, incoming value.
      new_col[0] = row_word.older;
      new_col[1] = row_word.newer;
      new_col[mlbc_pkg::WINDOW-1] = s1_pixel_ff;

      row_wdata.older = row_word.newer;
      row_wdata.newer = s1_pixel_ff;

      win_wdata.older = win_word.newer;
      win_wdata.newer = new_col;

      window[0] = win_word.older;
      window[1] = win_word.newer;
      window[mlbc_pkg::WINDOW-1] = new_col;

      for (int f = 0; f < mlbc_pkg::FILTERS; f++) begin
         ksum[f] = mlbc_pkg::kernel_sum(window, mlbc_pkg::FILT_BITS'(f));
      end
   end

   always_comb begin
      s1_valid_in     = req_ready ? req_valid : s1_valid_ff;
      s1_pixel_in     = s1_pixel_ff;
      s1_ch_in        = s1_ch_ff;
      s1_col_in       = s1_col_ff;
      s1_last_in      = s1_last_ff;
      s1_emit_in      = s1_emit_ff;
      s1_row_fwd_in   = s1_row_fwd_ff;
      s1_row_fdata_in = s1_row_fdata_ff;
      s1_win_fwd_in   = s1_win_fwd_ff;
      s1_win_fdata_in = s1_win_fdata_ff;
      if (accept) begin
         s1_pixel_in     = req_pixel;
         s1_ch_in        = ch_ff;
         s1_col_in       = col_ff;
         s1_last_in      = last_ch;
         s1_emit_in      = emit;
         // The memory returns old data when the write lands on the read edge.
         s1_row_fwd_in   = wr_en && (wr_addr == rd_addr);
         s1_row_fdata_in = row_wdata;
         s1_win_fwd_in   = wr_en && (s1_ch_ff == ch_ff);
         s1_win_fdata_in = win_wdata;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: accumulate across channels and hand a finished pixel over.
   // ---------------------------------------------------------------------
   logic                   s2_valid_ff, s2_valid_in;
   mlbc_pkg::ksum_vec_type s2_ksum_ff, s2_ksum_in;
   logic                   s2_last_ff, s2_last_in;
   logic                   s2_emit_ff, s2_emit_in;
   mlbc_pkg::sum_vec_type  acc_ff, acc_in;

   logic                        s2_go;
   logic                        load_valid;
   logic                        load_ready;
   mlbc_pkg::sum_group_type     load_group;
   logic [mlbc_pkg::SUM_BITS:0] total_wide [mlbc_pkg::FILTERS];
   logic [mlbc_pkg::FILTERS-1:0] acc_carry;

   always_comb begin
      for (int f = 0; f < mlbc_pkg::FILTERS; f++) begin
         total_wide[f] = (mlbc_pkg::SUM_BITS + 1)'(acc_ff[f]) +
                         (mlbc_pkg::SUM_BITS + 1)'(s2_ksum_ff[f]);
         acc_carry[f]  = total_wide[f][mlbc_pkg::SUM_BITS];
         load_group.sums[f] = total_wide[f][mlbc_pkg::SUM_BITS-1:0];
      end
   end

   assign load_valid = s2_valid_ff && s2_last_ff && s2_emit_ff;
   assign s2_go      = !(s2_last_ff && s2_emit_ff) || load_ready;
   assign s1_go      = !s2_valid_ff || s2_go;

   always_comb begin
      s2_valid_in = s1_go ? s1_valid_ff : s2_valid_ff;
      s2_ksum_in  = s2_ksum_ff;
      s2_last_in  = s2_last_ff;
      s2_emit_in  = s2_emit_ff;
      acc_in      = acc_ff;
      if (wr_en) begin
         s2_ksum_in = ksum;
         s2_last_in = s1_last_ff;
         s2_emit_in = s1_emit_ff;
      end
      if (s2_valid_ff && s2_go) begin
         // Partial sums restart after every pixel, emitted or not.
         acc_in = s2_last_ff ? '0 : load_group.sums;
      end
   end

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= mlbc_pkg::CC_RESET;
         img_width_ff  <= mlbc_pkg::IW_RESET;
         img_height_ff <= mlbc_pkg::IH_RESET;
         ch_ff         <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         acc_ff        <= '0;
      end else begin
         chan_count_ff <= chan_count_in;
         img_width_ff  <= img_width_in;
         img_height_ff <= img_height_in;
         ch_ff         <= ch_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         acc_ff        <= acc_in;
      end
      s1_pixel_ff     <= s1_pixel_in;
      s1_ch_ff        <= s1_ch_in;
      s1_col_ff       <= s1_col_in;
      s1_last_ff      <= s1_last_in;
      s1_emit_ff      <= s1_emit_in;
      s1_row_fwd_ff   <= s1_row_fwd_in;
      s1_row_fdata_ff <= s1_row_fdata_in;
      s1_win_fwd_ff   <= s1_win_fwd_in;
      s1_win_fdata_ff <= s1_win_fdata_in;
      s2_ksum_ff      <= s2_ksum_in;
      s2_last_ff      <= s2_last_in;
      s2_emit_ff      <= s2_emit_in;
   end

   // ---------------------------------------------------------------------
   // Result serializer.
   // ---------------------------------------------------------------------
   mlbc_rsp_serializer u_rsp_serializer (
      .clock            (clock),
      .reset            (reset),
      .load_valid       (load_valid),
      .load_ready       (load_ready),
      .load_group       (load_group),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sum          (rsp_sum),
      .rsp_filter_index (rsp_filter_index),
      .rsp_last         (rsp_last)
   );

`ifndef ASSERT_OFF
   // Back-pressure only starts from a full result side.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && !load_ready))
      else $error("req_ready low without a blocked pipeline");

   // A stalled stage 2 keeps its operands and the running sums.
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_go) |=>
         (s2_valid_ff && $stable(s2_ksum_ff) && $stable(acc_ff)))
      else $error("stage 2 changed while stalled");

   // Channel accumulation of a sent pixel never overflows the sum width.
   a_acc_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_emit_ff) |-> (acc_carry == '0))
      else $error("channel accumulator overflow");
`endif

endmodule
